[hw/rtl/ddsr_pkg.sv]
// ddsr_pkg: shared widths, command word type and sine magnitude function
`timescale 1ns / 1ps
`default_nettype none

package ddsr_pkg;

  // fixed field widths of the channels
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned WIN_W    = 13;
  localparam int unsigned PHASE_W  = 32;
  // ring offset carried in the command word, wide enough for the deepest ring
  localparam int unsigned OFFSET_W = 16;

  // fixed-point constants for the sine series
  localparam logic [63:0] TWO_PI_Q30 = 64'h0000_0001_921F_B544;
  localparam logic [63:0] ONE_Q30    = 64'h0000_0000_4000_0000;
  localparam logic [63:0] HALF_Q30   = 64'h0000_0000_2000_0000;
  localparam logic [63:0] MAG_LIM    = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

  typedef enum logic {
    OP_GEN  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // classified word passed from the front to the back
  typedef struct packed {
    op_e                 op;
    logic                in_window;
    logic [OFFSET_W-1:0] offset;
    logic [WIN_W-1:0]    window;
  } cmd_t;

  // sine magnitude for a first-quadrant angle r in Q30 turns of a quarter,
  // only ever called with constants while building the table
  function automatic logic [SAMPLE_W-1:0] sine_mag(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    x   = (r * TWO_PI_Q30) >> 32;
    x2  = (x * x) >> 30;
    t   = ONE_Q30 - x2 / 64'd110;
    t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s   = (x * t) >> 30;
    mag = ((s << (SAMPLE_W - 1)) + HALF_Q30) >> 30;
    if (mag > MAG_LIM) begin
      mag = MAG_LIM;
    end
    return mag[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ddsr_in_if.sv]
// ddsr_in_if: request channel carrying generate and read words
`timescale 1ns / 1ps
`default_nettype none

interface ddsr_in_if import ddsr_pkg::*;;
  logic               valid;
  logic               ready;
  logic               op;
  logic [COUNT_W-1:0] window_count;
  logic [COUNT_W-1:0] element_index;

  modport source (output valid, output op, output window_count, output element_index,
                  input ready);
  modport sink   (input valid, input op, input window_count, input element_index,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/ddsr_out_if.sv]
// ddsr_out_if: response channel carrying sample words
`timescale 1ns / 1ps
`default_nettype none

interface ddsr_out_if import ddsr_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       valid_res;
  logic [WIN_W-1:0]           window_size;

  modport source (output valid, output sample, output valid_res, output window_size,
                  input ready);
  modport sink   (input valid, input sample, input valid_res, input window_size,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/ddsr_ram.sv]
// ddsr_ram: simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module ddsr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/ddsr_front.sv]
// ddsr_front: accepts request words and classifies them into command words
`timescale 1ns / 1ps
`default_nettype none

module ddsr_front import ddsr_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 4096
) (
  ddsr_in_if.sink          req_i,
  output cmd_t             cmd_o,
  output logic             cmd_valid_o,
  input  wire logic        cmd_ready_i
);

  localparam int unsigned     EXT_W   = COUNT_W + 1;
  localparam logic [EXT_W-1:0] DEPTH_X = EXT_W'(BUFFER_DEPTH);

  logic [EXT_W-1:0] count_x;
  logic [EXT_W-1:0] index_x;
  logic [EXT_W-1:0] window_x;
  logic [EXT_W-1:0] offset_x;

  // clip the window and work out the ring offset relative to the write pointer
  always_comb begin
    count_x  = {1'b0, req_i.window_count};
    index_x  = {1'b0, req_i.element_index};
    window_x = (count_x < DEPTH_X) ? count_x : DEPTH_X;
    offset_x = DEPTH_X - window_x + index_x;
  end

  // command word
  always_comb begin
    cmd_o.op        = op_e'(req_i.op);
    cmd_o.in_window = index_x < window_x;
    cmd_o.offset    = offset_x[OFFSET_W-1:0];
    cmd_o.window    = window_x[WIN_W-1:0];
  end

  // handshake passes straight to the queue
  assign cmd_valid_o = req_i.valid;
  assign req_i.ready = cmd_ready_i;

endmodule

`default_nettype wire

[hw/rtl/ddsr_queue.sv]
// ddsr_queue: two-entry queue of command words between front and back
`timescale 1ns / 1ps
`default_nettype none

module ddsr_queue import ddsr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  // handshakes
  always_comb begin
    push_ready_o = count_q != CNT_W'(DEPTH);
    pop_valid_o  = count_q != '0;
    push         = push_valid_i && push_ready_o;
    pop          = pop_valid_o && pop_ready_i;
    pop_cmd_o    = slot_q[rd_ptr_q];
  end

  // pointer and fill update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("command queue over-filled");
`endif

endmodule

`default_nettype wire

[hw/rtl/ddsr_back.sv]
// ddsr_back: phase accumulator, sine table, ring store and response register
`timescale 1ns / 1ps
`default_nettype none

module ddsr_back import ddsr_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH     = 4096,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [PHASE_W-1:0] cfg_wdata_i,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_ready_o,
  input  wire cmd_t               cmd_i,
  ddsr_out_if.source              rsp_o
);

  localparam int unsigned      PTR_W      = $clog2(BUFFER_DEPTH);
  localparam int unsigned      SUM_W      = PTR_W + 1;
  localparam int unsigned      TABLE_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned      QUARTER    = SINE_TABLE_DEPTH / 4;
  localparam int unsigned      MIR_W      = TABLE_BITS - 1;
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_X    = SUM_W'(BUFFER_DEPTH);

  logic [PHASE_W-1:0]    step_q;
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [PTR_W-1:0]      wp_q, wp_d;
  logic                  wrapped_q, wrapped_d;

  logic [TABLE_BITS-1:0] tab_idx;
  logic [1:0]            quad;
  logic [TABLE_BITS-3:0] fine_idx;
  logic [MIR_W-1:0]      mir_idx;
  logic [SAMPLE_W-1:0]   mag_rom [QUARTER+1];
  logic [SAMPLE_W-1:0]   mag;
  logic [SAMPLE_W-1:0]   gen_sample;

  logic [SUM_W-1:0]      pos_sum;
  logic [PTR_W-1:0]      rd_pos;
  logic                  rd_written;

  logic                  pop;
  logic                  is_gen;
  logic                  ram_we;
  logic                  ram_re;
  logic [SAMPLE_W-1:0]   ram_rdata;

  logic                  out_valid_q, out_valid_d;
  logic                  out_read_q;
  logic                  out_hit_q;
  logic                  out_in_win_q;
  logic [SAMPLE_W-1:0]   out_gen_q;
  logic [WIN_W-1:0]      out_window_q;

  // quarter-wave magnitude table, built at elaboration
  for (genvar g = 0; g <= QUARTER; g++) begin : g_mag_rom
    assign mag_rom[g] = sine_mag(64'(g) << (PHASE_W - TABLE_BITS));
  end

  // sine lookup from the top phase bits with quadrant folding
  always_comb begin
    tab_idx    = phase_q[PHASE_W-1 -: TABLE_BITS];
    quad       = tab_idx[TABLE_BITS-1 -: 2];
    fine_idx   = tab_idx[TABLE_BITS-3:0];
    mir_idx    = quad[0] ? MIR_W'(QUARTER) - MIR_W'(fine_idx) : MIR_W'(fine_idx);
    mag        = mag_rom[mir_idx];
    gen_sample = quad[1] ? (~mag + 1'b1) : mag;
  end

  // ring position of a read word and whether it has been written since reset
  always_comb begin
    pos_sum    = SUM_W'(wp_q) + SUM_W'(cmd_i.offset[PTR_W-1:0]);
    rd_pos     = (pos_sum >= DEPTH_X) ? PTR_W'(pos_sum - DEPTH_X) : pos_sum[PTR_W-1:0];
    rd_written = wrapped_q || (rd_pos < wp_q);
  end

  // issue control
  always_comb begin
    cmd_ready_o = !out_valid_q || rsp_o.ready;
    pop         = cmd_valid_i && cmd_ready_o;
    is_gen      = cmd_i.op == OP_GEN;
    ram_we      = pop && is_gen;
    ram_re      = pop && !is_gen && cmd_i.in_window;
  end

  // phase and write pointer advance on each generate word
  always_comb begin
    phase_d   = phase_q;
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (ram_we) begin
      phase_d = phase_q + step_q;
      if (wp_q == PTR_LAST) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      phase_q   <= '0;
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      phase_q   <= phase_d;
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
    end
  end

  // ring store
  ddsr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (gen_sample),
    .re_i    (ram_re),
    .raddr_i (rd_pos),
    .rdata_o (ram_rdata)
  );

  // response register
  always_comb begin
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_read_q   <= !is_gen;
      out_hit_q    <= cmd_i.in_window && rd_written;
      out_in_win_q <= cmd_i.in_window;
      out_gen_q    <= gen_sample;
      out_window_q <= cmd_i.window;
    end
  end

  // response word
  always_comb begin
    rsp_o.valid       = out_valid_q;
    rsp_o.sample      = !out_read_q ? out_gen_q : (out_hit_q ? ram_rdata : '0);
    rsp_o.valid_res   = !out_read_q || out_in_win_q;
    rsp_o.window_size = out_read_q ? out_window_q : '0;
  end

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= PTR_LAST)
    else $error("ring write pointer beyond depth");

  a_phase_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> phase_q == $past(phase_q + step_q))
    else $error("phase did not advance by one step on generate");

  a_wrap_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && wp_q == PTR_LAST) |=> (wrapped_q && wp_q == '0))
    else $error("ring wrap not recorded");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("ring wrap flag cleared outside reset");
`endif

endmodule

`default_nettype wire

[hw/rtl/dds_sine_generator_with_ring_capture.sv]
// dds_sine_generator_with_ring_capture: top level of the sine generator with ring capture
//
// Usage:
//   req_i carries request words. op 0 generates one sine sample from the phase
//   accumulator, stores it in the ring and returns it. op 1 reads back the sample
//   at position element_index of the last window_count samples (clipped to the
//   ring depth), oldest first; an index outside the window gives valid_res 0.
//   rsp_o returns one word per request, in request order.
//   cfg_we_i / cfg_wdata_i write the phase step; write it only while idle.
// Timing:
//   A word accepted into the command queue is popped by the back end into the
//   response register and presented on rsp_o from there. One word per cycle is
//   sustained while rsp_o is not stalled: the phase add, table lookup and ring write
//   or ring read issue on the pop, the ring read data landing in the response stage.
// Reset:
//   Phase, step, write pointer and queue are cleared. The ring needs no clearing
//   pass: a wrap flag and the write pointer mark which entries were written, and
//   unwritten entries read as zero.
// Stalls:
//   While rsp_o is stalled the response is held, and up to two more request
//   words are taken into the command queue before req_i.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module dds_sine_generator_with_ring_capture import ddsr_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH     = 4096,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [PHASE_W-1:0] cfg_wdata_i,
  ddsr_in_if.sink                 req_i,
  ddsr_out_if.source              rsp_o
);

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  // classify incoming words
  ddsr_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_front (
    .req_i       (req_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  // decouple front and back
  ddsr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  // generate, store and read back
  ddsr_back #(
    .BUFFER_DEPTH     (BUFFER_DEPTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
